@@ hdl/dtf_pkg.sv @@
// Shared types and constants for the decimal text to float converter.
`timescale 1ns / 1ps

package dtf_pkg;

  localparam int unsigned MaxCharsDef = 16;
  localparam int unsigned MaxFracDef  = 9;

  // Fraction digits stay below 10^9 and their scale reaches at most 10^9
  localparam int unsigned FracW = 30;
  localparam int unsigned ExpW  = 7;
  localparam int unsigned ExW   = 12;
  localparam int unsigned ManW  = 53;
  localparam int unsigned AccW  = 120;

  localparam logic [ExpW-1:0] ExpSat = 7'd64;

  localparam logic [ManW-1:0] ManOne = 53'd1 << 52;
  localparam logic [ManW-1:0] Man1e8 = 53'd100000000 << 26;
  localparam logic [ManW-1:0] Man10  = 53'd10 << 49;

  typedef struct packed {
    logic                  zero;
    logic                  sgn;
    logic signed [ExW-1:0] ex;
    logic [ManW-1:0]       man;
  } dbl_t;

  localparam dbl_t DblOne = '{zero: 1'b0, sgn: 1'b0, ex: 12'sd0, man: ManOne};
  localparam dbl_t Dbl1e8 = '{zero: 1'b0, sgn: 1'b0, ex: 12'sd26, man: Man1e8};
  localparam dbl_t Dbl10  = '{zero: 1'b0, sgn: 1'b0, ex: 12'sd3, man: Man10};

  typedef struct packed {
    logic             negative;
    logic [31:0]      int_digits;
    logic [FracW-1:0] frac_digits;
    logic [FracW-1:0] frac_scale;
    logic             exp_negative;
    logic [ExpW-1:0]  exp_value;
  } token_t;

endpackage

@@ hdl/dtf_in_if.sv @@
// Character channel: one text character per word, last marks the token end.
`timescale 1ns / 1ps

interface dtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

@@ hdl/dtf_out_if.sv @@
// Result channel: one single-precision bit pattern per word.
`timescale 1ns / 1ps

interface dtf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink (input valid, input float_bits, output ready);
endinterface

@@ hdl/dtf_parse.sv @@
// Token parser: folds each character into sign, digit and exponent fields.
`timescale 1ns / 1ps

module dtf_parse #(
  parameter int unsigned MAX_CHARS       = dtf_pkg::MaxCharsDef,
  parameter int unsigned MAX_FRAC_DIGITS = dtf_pkg::MaxFracDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      ch_i,
  input  logic            clear_i,
  output dtf_pkg::token_t tok_o
);
  import dtf_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CHARS);

  typedef enum logic [5:0] {
    PH_SIGN  = 6'b000001,
    PH_INT   = 6'b000010,
    PH_FRAC  = 6'b000100,
    PH_ESIGN = 6'b001000,
    PH_EXP   = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  phase_e          phase_q, phase_d;
  token_t          tok_q, tok_d;
  logic [3:0]      fcnt_q, fcnt_d;
  logic [CntW-1:0] count_q, count_d;

  logic       is_dig, is_sign, is_minus, is_e, is_pt;
  logic [3:0] dig;
  logic [9:0] exp_nx;

  assign dig      = ch_i[3:0];
  assign is_dig   = (ch_i >= 8'h30) && (ch_i <= 8'h39);
  assign is_minus = (ch_i == 8'h2D);
  assign is_sign  = (ch_i == 8'h2B) || is_minus;
  assign is_e     = (ch_i == 8'h65) || (ch_i == 8'h45);
  assign is_pt    = (ch_i == 8'h2E);
  assign exp_nx   = {tok_q.exp_value, 3'b000} + {2'b00, tok_q.exp_value, 1'b0} + 10'(dig);

  always_comb begin
    logic hit;
    hit     = 1'b0;
    phase_d = phase_q;
    tok_d   = tok_q;
    fcnt_d  = fcnt_q;
    count_d = count_q;
    if (clear_i) begin
      phase_d = PH_SIGN;
      tok_d   = '{negative: 1'b0, int_digits: '0, frac_digits: '0,
                  frac_scale: FracW'(1), exp_negative: 1'b0, exp_value: '0};
      fcnt_d  = '0;
      count_d = '0;
    end else if (take_i && (count_q < CntW'(MAX_CHARS - 1))) begin
      count_d = count_q + CntW'(1);
      if (phase_q != PH_DONE) begin
        if (phase_d == PH_SIGN) begin
          phase_d = PH_INT;
          if (is_sign) begin
            tok_d.negative = is_minus;
            hit = 1'b1;
          end
        end
        if (!hit && phase_d == PH_INT) begin
          hit = 1'b1;
          if (is_dig) begin
            tok_d.int_digits = {tok_q.int_digits[28:0], 3'b000} +
                               {tok_q.int_digits[30:0], 1'b0} + 32'(dig);
          end else if (is_pt) begin
            phase_d = PH_FRAC;
          end else if (is_e) begin
            phase_d = PH_ESIGN;
          end else begin
            phase_d = PH_DONE;
          end
        end
        if (!hit && phase_d == PH_FRAC) begin
          hit = 1'b1;
          if (is_dig) begin
            // drop digits past the kept precision
            if (fcnt_q < 4'(MAX_FRAC_DIGITS)) begin
              tok_d.frac_digits = {tok_q.frac_digits[FracW-4:0], 3'b000} +
                                  {tok_q.frac_digits[FracW-2:0], 1'b0} + FracW'(dig);
              tok_d.frac_scale  = {tok_q.frac_scale[FracW-4:0], 3'b000} +
                                  {tok_q.frac_scale[FracW-2:0], 1'b0};
              fcnt_d = fcnt_q + 4'd1;
            end
          end else if (is_e) begin
            phase_d = PH_ESIGN;
          end else begin
            phase_d = PH_DONE;
          end
        end
        if (!hit && phase_d == PH_ESIGN) begin
          phase_d = PH_EXP;
          if (is_sign) begin
            tok_d.exp_negative = is_minus;
            hit = 1'b1;
          end
        end
        if (!hit && phase_d == PH_EXP) begin
          if (is_dig) begin
            tok_d.exp_value = (exp_nx > 10'(ExpSat)) ? ExpSat : exp_nx[ExpW-1:0];
          end else begin
            phase_d = PH_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIGN;
      tok_q   <= '{negative: 1'b0, int_digits: '0, frac_digits: '0,
                   frac_scale: FracW'(1), exp_negative: 1'b0, exp_value: '0};
      fcnt_q  <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      tok_q   <= tok_d;
      fcnt_q  <= fcnt_d;
      count_q <= count_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ hdl/dtf_core.sv @@
// Sequencer and shared 120-bit datapath that forms the value and rounds it.
`timescale 1ns / 1ps

module dtf_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  dtf_pkg::token_t tok_i,
  input  logic            res_free_i,
  output logic            idle_o,
  output logic            clear_o,
  output logic            res_we_o,
  output logic [31:0]     res_o
);
  import dtf_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_CVF   = 16'h0002,
    ST_CVK   = 16'h0004,
    ST_DIVQ  = 16'h0008,
    ST_DIV   = 16'h0010,
    ST_NORM  = 16'h0020,
    ST_RND   = 16'h0040,
    ST_ADDLD = 16'h0080,
    ST_ALN   = 16'h0100,
    ST_SC0   = 16'h0200,
    ST_SC1   = 16'h0400,
    ST_SC2   = 16'h0800,
    ST_VAL   = 16'h1000,
    ST_MUL   = 16'h2000,
    ST_FL    = 16'h4000,
    ST_DEN   = 16'h8000
  } state_e;

  localparam logic signed [ExW-1:0] AddEx   = 12'sd36;
  localparam logic signed [ExW-1:0] IntEx   = 12'sd31;
  localparam logic signed [ExW-1:0] MulEx   = 12'sd15;
  localparam logic signed [ExW-1:0] FMinEx  = -12'sd126;
  localparam logic signed [ExW-1:0] FBias   = 12'sd127;
  localparam logic signed [ExW-1:0] FBiasP1 = 12'sd128;
  localparam logic signed [ExW-1:0] FExpMax = 12'sd255;

  state_e                state_q, state_d, ret_q, ret_d;
  logic [AccW-1:0]       acc_q, acc_d;
  logic signed [ExW-1:0] ex_q, ex_d;
  logic                  sgn_q, sgn_d, stk_q, stk_d;
  logic [ManW:0]         rem_q, rem_d;
  logic [ManW-1:0]       dvs_q, dvs_d;
  logic [6:0]            cnt_q, cnt_d;
  logic [3:0]            e8_q, e8_d;
  logic [2:0]            e1_q, e1_d;
  dbl_t                  r_q, r_d, fd_q, fd_d, sd_q, sd_d, vd_q, vd_d;

  // integer part as sign and magnitude
  logic        a_neg;
  logic [31:0] a_mag;
  assign a_neg = tok_i.int_digits[31];
  assign a_mag = a_neg ? (~tok_i.int_digits + 32'd1) : tok_i.int_digits;

  // round to double
  logic [ManW-1:0] dr_m;
  logic            dr_up;
  logic [ManW:0]   dr_sum;
  assign dr_m   = acc_q[AccW-1 -: ManW];
  assign dr_up  = acc_q[AccW-1-ManW] & ((|acc_q[AccW-2-ManW:0]) | dr_m[0]);
  assign dr_sum = {1'b0, dr_m} + (ManW+1)'(dr_up);

  // divide step
  logic          dv_ge;
  logic [ManW:0] dv_rn;
  assign dv_ge = rem_q >= {1'b0, dvs_q};
  assign dv_rn = dv_ge ? (rem_q - {1'b0, dvs_q}) : rem_q;

  // round to single
  logic [23:0]           fr_m;
  logic                  fr_up;
  logic [24:0]           fr_sum;
  logic signed [ExW-1:0] fr_bexp;
  logic [22:0]           fr_frac;
  logic [31:0]           fr_bits;
  assign fr_m   = acc_q[AccW-1 -: 24];
  assign fr_up  = acc_q[AccW-25] & ((|acc_q[AccW-26:0]) | stk_q | fr_m[0]);
  assign fr_sum = {1'b0, fr_m} + 25'(fr_up);

  always_comb begin
    if (fr_sum[24]) begin
      fr_bexp = ex_q + FBiasP1;
      fr_frac = fr_sum[23:1];
    end else if (fr_sum[23]) begin
      fr_bexp = ex_q + FBias;
      fr_frac = fr_sum[22:0];
    end else begin
      fr_bexp = '0;
      fr_frac = fr_sum[22:0];
    end
    if (r_q.zero) begin
      fr_bits = {sgn_q, 31'd0};
    end else if (fr_bexp >= FExpMax) begin
      fr_bits = {sgn_q, 8'hFF, 23'd0};
    end else begin
      fr_bits = {sgn_q, fr_bexp[7:0], fr_frac};
    end
  end

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    acc_d    = acc_q;
    ex_d     = ex_q;
    sgn_d    = sgn_q;
    stk_d    = stk_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    cnt_d    = cnt_q;
    e8_d     = e8_q;
    e1_d     = e1_q;
    r_d      = r_q;
    fd_d     = fd_q;
    sd_d     = sd_q;
    vd_d     = vd_q;
    clear_o  = 1'b0;
    res_we_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_CVF;
        end
      end
      ST_CVF: begin
        if (tok_i.frac_digits == '0) begin
          r_d.zero = 1'b1;
          r_d.sgn  = 1'b0;
          state_d  = ST_ADDLD;
        end else begin
          acc_d   = {2'b00, tok_i.frac_digits, 88'd0};
          ex_d    = IntEx;
          sgn_d   = 1'b0;
          ret_d   = ST_CVK;
          state_d = ST_NORM;
        end
      end
      ST_CVK: begin
        fd_d    = r_q;
        acc_d   = {2'b00, tok_i.frac_scale, 88'd0};
        ex_d    = IntEx;
        sgn_d   = 1'b0;
        ret_d   = ST_DIVQ;
        state_d = ST_NORM;
      end
      ST_DIVQ: begin
        rem_d   = {1'b0, fd_q.man};
        dvs_d   = r_q.man;
        ex_d    = fd_q.ex - r_q.ex;
        sgn_d   = 1'b0;
        acc_d   = '0;
        cnt_d   = '0;
        ret_d   = ST_ADDLD;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = {dv_rn[ManW-1:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        // fold the remainder into the last quotient bit as sticky
        if (cnt_q == 7'(AccW - 1)) begin
          acc_d   = {acc_q[AccW-2:0], dv_ge | (dv_rn != '0)};
          state_d = ST_NORM;
        end else begin
          acc_d = {acc_q[AccW-2:0], dv_ge};
        end
      end
      ST_MUL: begin
        acc_d = {acc_q[AccW-2:0], 1'b0} +
                (rem_q[ManW-1] ? {{(AccW-ManW){1'b0}}, dvs_q} : '0);
        rem_d = {rem_q[ManW-1:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(ManW - 1)) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (acc_q == '0) begin
          r_d.zero = 1'b1;
          r_d.sgn  = sgn_q;
          state_d  = ret_q;
        end else if (!acc_q[AccW-1]) begin
          acc_d = {acc_q[AccW-2:0], 1'b0};
          ex_d  = ex_q - 12'sd1;
        end else begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        r_d.zero = 1'b0;
        r_d.sgn  = sgn_q;
        if (dr_sum[ManW]) begin
          r_d.man = dr_sum[ManW:1];
          r_d.ex  = ex_q + 12'sd1;
        end else begin
          r_d.man = dr_sum[ManW-1:0];
          r_d.ex  = ex_q;
        end
        state_d = ret_q;
      end
      ST_ADDLD: begin
        if (r_q.zero) begin
          acc_d = '0;
          ex_d  = AddEx;
        end else begin
          acc_d = {r_q.man, {(AccW-ManW){1'b0}}};
          ex_d  = r_q.ex;
        end
        state_d = ST_ALN;
      end
      ST_ALN: begin
        // align the fraction to the fixed point of the integer part
        if (ex_q < AddEx) begin
          acc_d = {1'b0, acc_q[AccW-1:1]};
          ex_d  = ex_q + 12'sd1;
        end else begin
          acc_d   = a_neg ? ({5'd0, a_mag, 83'd0} - acc_q) : ({5'd0, a_mag, 83'd0} + acc_q);
          sgn_d   = a_neg;
          ret_d   = ST_SC0;
          state_d = ST_NORM;
        end
      end
      ST_SC0: begin
        vd_d    = r_q;
        sd_d    = DblOne;
        e8_d    = 4'(tok_i.exp_value >> 3);
        e1_d    = tok_i.exp_value[2:0];
        state_d = ST_SC1;
      end
      ST_SC1: begin
        if (e8_q != '0 || e1_q != '0) begin
          acc_d   = '0;
          cnt_d   = '0;
          dvs_d   = sd_q.man;
          sgn_d   = 1'b0;
          ret_d   = ST_SC2;
          state_d = ST_MUL;
          if (e8_q != '0) begin
            rem_d = {1'b0, Dbl1e8.man};
            ex_d  = sd_q.ex + Dbl1e8.ex + MulEx;
            e8_d  = e8_q - 4'd1;
          end else begin
            rem_d = {1'b0, Dbl10.man};
            ex_d  = sd_q.ex + Dbl10.ex + MulEx;
            e1_d  = e1_q - 3'd1;
          end
        end else begin
          state_d = ST_VAL;
        end
      end
      ST_SC2: begin
        sd_d    = r_q;
        state_d = ST_SC1;
      end
      ST_VAL: begin
        acc_d = '0;
        cnt_d = '0;
        sgn_d = vd_q.sgn;
        ret_d = ST_FL;
        if (vd_q.zero) begin
          r_d     = vd_q;
          state_d = ST_FL;
        end else if (tok_i.exp_negative) begin
          rem_d   = {1'b0, vd_q.man};
          dvs_d   = sd_q.man;
          ex_d    = vd_q.ex - sd_q.ex;
          state_d = ST_DIV;
        end else begin
          rem_d   = {1'b0, sd_q.man};
          dvs_d   = vd_q.man;
          ex_d    = vd_q.ex + sd_q.ex + MulEx;
          state_d = ST_MUL;
        end
      end
      ST_FL: begin
        acc_d   = {r_q.man, {(AccW-ManW){1'b0}}};
        ex_d    = r_q.ex;
        sgn_d   = r_q.sgn ^ tok_i.negative;
        stk_d   = 1'b0;
        state_d = ST_DEN;
      end
      ST_DEN: begin
        // shift down into the subnormal range, keep lost bits as sticky
        if (!r_q.zero && (ex_q < FMinEx)) begin
          acc_d = {1'b0, acc_q[AccW-1:1]};
          stk_d = stk_q | acc_q[0];
          ex_d  = ex_q + 12'sd1;
        end else if (res_free_i) begin
          res_we_o = 1'b1;
          clear_o  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      cnt_q   <= '0;
      e8_q    <= '0;
      e1_q    <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      e8_q    <= e8_d;
      e1_q    <= e1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ex_q  <= ex_d;
    sgn_q <= sgn_d;
    stk_q <= stk_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    r_q   <= r_d;
    fd_q  <= fd_d;
    sd_q  <= sd_d;
    vd_q  <= vd_d;
  end

  assign idle_o = (state_q == ST_IDLE);
  assign res_o  = fr_bits;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("token end taken while busy");

  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we_o |-> res_free_i)
    else $error("result written over a pending word");

  a_rnd_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RND |-> acc_q[AccW-1])
    else $error("rounding an unnormalized accumulator");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < {dvs_q, 1'b0})
    else $error("partial remainder out of range");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we_o |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle");

endmodule

@@ hdl/decimal_text_to_float_top.sv @@
// Top level of the decimal text to single-precision float converter.
//
//  channel  dir  payload                 word
//  in_i     in   ch[7:0], last           one character of a number token
//  out_o    out  float_bits[31:0]        one result per token (on last)
//
// A character without the last mark is taken whenever the converter is idle. The last
// character starts the value computation on one shared 120-bit add/shift datapath: the
// 120-step fraction divide, one 53-step multiply per power-of-ten block (up to 14), the
// final multiply or divide and the normalize/denormal shift loops set the time taken per
// token. in_i.ready is low during that time. A finished word waits in the output register
// while the next token's characters are taken. Reset clears control state and the parser's
// token fields; the core datapath and the output word are not reset, and there is no
// memory to sweep.
`timescale 1ns / 1ps

module decimal_text_to_float_top #(
  parameter int unsigned MAX_CHARS       = dtf_pkg::MaxCharsDef,
  parameter int unsigned MAX_FRAC_DIGITS = dtf_pkg::MaxFracDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtf_in_if.sink    in_i,
  dtf_out_if.source out_o
);
  import dtf_pkg::*;

  token_t      tok;
  logic        idle, take, start, clear, res_we, res_free;
  logic [31:0] res;
  logic        out_valid_q;
  logic [31:0] out_bits_q;

  assign in_i.ready = idle;
  assign take       = in_i.valid && in_i.ready;
  assign start      = take && in_i.last;
  assign res_free   = !out_valid_q || out_o.ready;

  dtf_parse #(
    .MAX_CHARS       (MAX_CHARS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .ch_i    (in_i.ch),
    .clear_i (clear),
    .tok_o   (tok)
  );

  dtf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .tok_i      (tok),
    .res_free_i (res_free),
    .idle_o     (idle),
    .clear_o    (clear),
    .res_we_o   (res_we),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_we) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      out_bits_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.float_bits = out_bits_q;

endmodule
